// File: hdl/tlvt_pkg.sv
// ----------------------------------------------------------------------------
// tlvt_pkg
// Shared types and codes of the TLV stream tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package tlvt_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [3:0] K_NULL   = 4'd0;
  localparam logic [3:0] K_BOOL   = 4'd1;
  localparam logic [3:0] K_UINT   = 4'd2;
  localparam logic [3:0] K_SINT   = 4'd3;
  localparam logic [3:0] K_F32    = 4'd4;
  localparam logic [3:0] K_F64    = 4'd5;
  localparam logic [3:0] K_BYTES  = 4'd6;
  localparam logic [3:0] K_STRING = 4'd7;
  localparam logic [3:0] K_ARRAY  = 4'd8;
  localparam logic [3:0] K_OBJECT = 4'd9;
  localparam logic [3:0] K_PAY    = 4'd10;
  localparam logic [3:0] K_ERR    = 4'd11;

  localparam logic [7:0] TOP_MASK   = 8'hE0;
  localparam logic [7:0] LOW_MASK   = 8'h0F;
  localparam logic [7:0] SIGN_BIT   = 8'h10;
  localparam logic [7:0] TOP_NULL   = 8'h00;
  localparam logic [7:0] TOP_BOOL   = 8'h20;
  localparam logic [7:0] TOP_BYTES  = 8'h40;
  localparam logic [7:0] TOP_STRING = 8'h60;
  localparam logic [7:0] TOP_INT    = 8'h80;
  localparam logic [7:0] TOP_FLOAT  = 8'hA0;
  localparam logic [7:0] TOP_ARRAY  = 8'hC0;

  localparam logic [3:0] LOW_FALSE = 4'h0;
  localparam logic [3:0] LOW_TRUE  = 4'hF;
  localparam logic [3:0] LOW_MAX   = 4'd8;
  localparam logic [3:0] LOW_F32   = 4'd4;
  localparam logic [3:0] LOW_F64   = 4'd8;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_INT,
    PH_FLOAT,
    PH_LEN,
    PH_PAYLOAD
  } phase_t;

  typedef enum logic [1:0] {
    OP_TOKEN,
    OP_INT,
    OP_FLT
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [3:0]  kind;
    logic [63:0] value;
    logic [7:0]  data;
    logic        last;
    logic        first;
    logic        done;
  } qent_t;

endpackage

`default_nettype wire

// File: hdl/tlvt_front.sv
// ----------------------------------------------------------------------------
// tlvt_front
// Accepts stream words, tracks the parse phase and header lengths, and
// queues at most one operation for each accepted word.
// ----------------------------------------------------------------------------
`default_nettype none

module tlvt_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [7:0]     in_byte,
  input  wire logic           q_ready,
  output logic                q_push,
  output tlvt_pkg::qent_t     q_ent
);
  import tlvt_pkg::*;

  phase_t      phase, phase_next;
  logic [3:0]  pending_kind, pending_kind_next;
  logic [3:0]  left, left_next;
  logic        first, first_next;
  logic [63:0] len_acc, len_acc_next;
  logic [63:0] payload_left, payload_left_next;
  logic        ent_valid;
  logic        accept;
  logic [7:0]  top;
  logic [3:0]  low;
  logic [63:0] len_shift;
  logic        pay_last;

  assign in_ready = q_ready;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && ent_valid;
  assign top      = in_byte & TOP_MASK;
  assign low      = 4'(in_byte & LOW_MASK);
  assign len_shift = {len_acc[55:0], in_byte};
  assign pay_last  = (payload_left[63:1] == 63'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      pending_kind <= K_NULL;
      left         <= 4'd0;
      first        <= 1'b0;
      len_acc      <= 64'd0;
      payload_left <= 64'd0;
    end else if (accept) begin
      phase        <= phase_next;
      pending_kind <= pending_kind_next;
      left         <= left_next;
      first        <= first_next;
      len_acc      <= len_acc_next;
      payload_left <= payload_left_next;
    end
  end

  always_comb begin
    phase_next        = phase;
    pending_kind_next = pending_kind;
    left_next         = left;
    first_next        = first;
    len_acc_next      = len_acc;
    payload_left_next = payload_left;
    ent_valid         = 1'b0;
    q_ent.op          = OP_TOKEN;
    q_ent.kind        = K_NULL;
    q_ent.value       = 64'd0;
    q_ent.data        = in_byte;
    q_ent.last        = 1'b0;
    q_ent.first       = first;
    q_ent.done        = (left == 4'd1);
    case (phase)
      PH_INT, PH_FLOAT: begin
        ent_valid  = 1'b1;
        q_ent.op   = (phase == PH_INT) ? OP_INT : OP_FLT;
        q_ent.kind = pending_kind;
        first_next = 1'b0;
        left_next  = left - 4'd1;
        if (left == 4'd1) begin
          phase_next = PH_IDLE;
        end
      end
      PH_LEN: begin
        len_acc_next = len_shift;
        left_next    = left - 4'd1;
        if (left == 4'd1) begin
          ent_valid   = 1'b1;
          q_ent.kind  = pending_kind;
          q_ent.value = len_shift;
          if ((pending_kind == K_BYTES || pending_kind == K_STRING) &&
              len_shift != 64'd0) begin
            payload_left_next = len_shift;
            phase_next        = PH_PAYLOAD;
          end else begin
            phase_next = PH_IDLE;
          end
        end
      end
      PH_PAYLOAD: begin
        ent_valid   = 1'b1;
        q_ent.kind  = K_PAY;
        q_ent.value = {56'd0, in_byte};
        q_ent.last  = pay_last;
        if (pay_last) begin
          payload_left_next = 64'd0;
          phase_next        = PH_IDLE;
        end else begin
          payload_left_next = payload_left - 64'd1;
        end
      end
      default: begin
        phase_next = PH_IDLE;
        case (top)
          TOP_NULL: begin
            ent_valid  = 1'b1;
            q_ent.kind = K_NULL;
          end
          TOP_BOOL: begin
            ent_valid = 1'b1;
            if (low == LOW_FALSE) begin
              q_ent.kind = K_BOOL;
            end else if (low == LOW_TRUE) begin
              q_ent.kind  = K_BOOL;
              q_ent.value = 64'd1;
            end else begin
              q_ent.kind  = K_ERR;
              q_ent.value = {56'd0, in_byte};
            end
          end
          TOP_INT: begin
            if (low > LOW_MAX) begin
              ent_valid   = 1'b1;
              q_ent.kind  = K_ERR;
              q_ent.value = {56'd0, in_byte};
            end else begin
              pending_kind_next = ((in_byte & SIGN_BIT) != 8'd0) ? K_SINT : K_UINT;
              if (low == 4'd0) begin
                ent_valid  = 1'b1;
                q_ent.kind = pending_kind_next;
              end else begin
                left_next  = low;
                first_next = 1'b1;
                phase_next = PH_INT;
              end
            end
          end
          TOP_FLOAT: begin
            if (low != LOW_F32 && low != LOW_F64) begin
              ent_valid   = 1'b1;
              q_ent.kind  = K_ERR;
              q_ent.value = {56'd0, in_byte};
            end else begin
              pending_kind_next = (low == LOW_F32) ? K_F32 : K_F64;
              left_next         = low;
              first_next        = 1'b1;
              phase_next        = PH_FLOAT;
            end
          end
          default: begin
            if (low > LOW_MAX) begin
              ent_valid   = 1'b1;
              q_ent.kind  = K_ERR;
              q_ent.value = {56'd0, in_byte};
            end else begin
              if (top == TOP_BYTES) begin
                pending_kind_next = K_BYTES;
              end else if (top == TOP_STRING) begin
                pending_kind_next = K_STRING;
              end else if (top == TOP_ARRAY) begin
                pending_kind_next = K_ARRAY;
              end else begin
                pending_kind_next = K_OBJECT;
              end
              len_acc_next = 64'd0;
              if (low == 4'd0) begin
                ent_valid  = 1'b1;
                q_ent.kind = pending_kind_next;
              end else begin
                left_next  = low;
                phase_next = PH_LEN;
              end
            end
          end
        endcase
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/tlvt_queue.sv
// ----------------------------------------------------------------------------
// tlvt_queue
// Short first-in first-out queue of operations between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module tlvt_queue #(
  parameter int DEPTH = tlvt_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire tlvt_pkg::qent_t  push_ent,
  output logic                  push_ready,
  input  wire logic             pop,
  output logic                  pop_valid,
  output tlvt_pkg::qent_t       pop_ent
);
  import tlvt_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  qent_t         slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign push_ready = (count != CNT_FULL);
  assign pop_valid  = (count != '0);
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_ent    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/tlvt_back.sv
// ----------------------------------------------------------------------------
// tlvt_back
// Carries out queued operations: assembles integers and floats, negates
// signed magnitudes and holds the result token in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tlvt_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_valid,
  input  wire tlvt_pkg::qent_t  q_ent,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [3:0]            token_kind,
  output logic [63:0]           token_value,
  output logic                  last_payload
);
  import tlvt_pkg::*;

  logic [63:0] acc, acc_next;
  logic        emits;
  logic        slot_free;
  logic [63:0] value_next;

  assign slot_free = !out_valid || out_ready;
  assign emits     = (q_ent.op == OP_TOKEN) || q_ent.done;
  assign q_pop     = q_valid && (!emits || slot_free);

  always_comb begin
    acc_next   = acc;
    value_next = q_ent.value;
    case (q_ent.op)
      OP_INT: begin
        acc_next   = q_ent.first ? {56'd0, q_ent.data} : {acc[55:0], q_ent.data};
        value_next = (q_ent.kind == K_SINT) ? 64'd0 - acc_next : acc_next;
      end
      OP_FLT: begin
        acc_next   = q_ent.first ? {q_ent.data, 56'd0} : {q_ent.data, acc[63:8]};
        value_next = (q_ent.kind == K_F32) ? {32'd0, acc_next[63:32]} : acc_next;
      end
      default: begin
        value_next = q_ent.value;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      acc <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop && emits) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emits) begin
      token_kind   <= q_ent.kind;
      token_value  <= value_next;
      last_payload <= q_ent.last;
    end
  end

endmodule

`default_nettype wire

// File: hdl/tlv_stream_tokenizer_top.sv
// ----------------------------------------------------------------------------
// tlv_stream_tokenizer_top
// Splits a type-length-value byte stream into tokens.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_ready / in_byte, one stream word per handshake.
// Output channel: out_valid / out_ready with token_kind, token_value and
// last_payload, at most one token per input word.
// Throughput: one word per cycle while the queue has room, set by the
// front phase tracker, which decides each word combinationally, and by
// the back, which retires one queued operation per cycle while unstalled.
// A token passes from the word that completes it through the queue slot
// (written at the accepting edge) into the output register of the back.
// Words that complete no token (type bytes of multi-byte fields, leading
// length bytes) only advance the front state and cost no output slot.
// When the receiver stalls, the token holds in the output register, the
// queue fills, and in_ready drops once QUEUE_DEPTH operations wait.
// Reset (synchronous, active high) returns the parser to expect a type byte
// and empties the queue and the output register; no clearing pass is run.
// ----------------------------------------------------------------------------
`default_nettype none

module tlv_stream_tokenizer_top #(
  parameter int QUEUE_DEPTH = tlvt_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       token_kind,
  output logic [63:0]      token_value,
  output logic             last_payload
);
  import tlvt_pkg::*;

  qent_t push_ent, pop_ent;
  logic  push, push_ready, pop, pop_valid;

  tlvt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .q_ready  (push_ready),
    .q_push   (push),
    .q_ent    (push_ent)
  );

  tlvt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ent   (push_ent),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_ent    (pop_ent)
  );

  tlvt_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (pop_valid),
    .q_ent        (pop_ent),
    .q_pop        (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .token_kind   (token_kind),
    .token_value  (token_value),
    .last_payload (last_payload)
  );

endmodule

`default_nettype wire

// File: hdl/tlvt_checker.sv
// ----------------------------------------------------------------------------
// tlvt_checker
// Port-level checks of the tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tlvt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [3:0]  token_kind,
  input wire logic [63:0] token_value,
  input wire logic        last_payload
);
  import tlvt_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_last_is_payload: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_payload) |-> (token_kind == K_PAY))
    else $error("last_payload on a non-payload token");

  a_small_values: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (token_kind == K_PAY || token_kind == K_ERR)) |->
    (token_value[63:8] == 56'd0))
    else $error("payload or error token wider than a word");

  a_null_bool: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (token_kind == K_NULL || token_kind == K_BOOL)) |->
    (token_value[63:1] == 63'd0 && (token_kind == K_BOOL || !token_value[0])))
    else $error("bad null or bool value");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(token_value) &&
    $stable(token_kind)))
    else $error("stalled token changed");

endmodule

bind tlv_stream_tokenizer_top tlvt_checker u_tlvt_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .token_kind   (token_kind),
  .token_value  (token_value),
  .last_payload (last_payload)
);

`default_nettype wire
